// File: hw/rtl/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/fpbs_pkg.sv
// shared types, operation codes and conversion helpers of the bitwise shift unit
`default_nettype none
package fpbs_pkg;
	localparam int unsigned WordBits = 64;

	typedef enum logic [3:0] {
		OP_ROL = 4'd0, OP_ROR = 4'd1, OP_AND = 4'd2, OP_NOR = 4'd3, OP_OR = 4'd4,
		OP_SLA = 4'd5, OP_SLL = 4'd6, OP_SRA = 4'd7, OP_SRL = 4'd8, OP_XOR = 4'd9
	} op_kind_t;

	typedef logic [WordBits-1:0] word_t;

	// truncate binary64 toward zero to a signed 64-bit pattern with saturation
	function automatic word_t to_signed(input word_t x);
		logic [10:0] e;
		logic [52:0] sig;
		logic        neg;
		logic        ovf;
		word_t       mag;
		word_t       r;
		e   = x[62:52];
		sig = {1'b1, x[51:0]};
		neg = x[63];
		ovf = 1'b0;
		mag = '0;
		if (e == 11'h7ff) begin
			if (x[51:0] != '0) neg = 1'b0;
			else ovf = 1'b1;
		end else if (e < 11'd1023) begin
			mag = '0;
		end else if (e >= 11'd1075) begin
			if (e - 11'd1075 > 11'd11) ovf = 1'b1;
			else mag = {11'd0, sig} << (e - 11'd1075);
		end else begin
			mag = {11'd0, sig} >> (11'd1075 - e);
		end
		if (!neg) r = (ovf || mag[63]) ? {1'b0, {63{1'b1}}} : mag;
		else if (ovf || (mag[63] && mag[62:0] != '0)) r = {1'b1, 63'd0};
		else r = word_t'(0) - mag;
		return r;
	endfunction

	// unsigned truncation; negatives take the signed pattern
	function automatic word_t to_unsigned(input word_t x);
		word_t r;
		r = to_signed(x);
		if (!x[63] && x[62:52] == 11'h7ff && x[51:0] == '0) r = '1;
		else if (!x[63] && x[62:52] >= 11'd1087 && x[62:52] != 11'h7ff) r = '1;
		else if (!x[63] && x[62:52] == 11'd1086) r = {1'b1, x[51:0], 11'd0};
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/fpbs_int_to_f64.sv
// integer to binary64 conversion, registered normalise then combinational round to nearest even
`default_nettype none
module fpbs_int_to_f64 (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire fpbs_pkg::word_t      mag,
	input  wire logic                 neg,
	output      fpbs_pkg::word_t      result
);
	import fpbs_pkg::*;

	logic [5:0] lead;
	logic       nz;
	word_t      norm_s1;
	logic [5:0] lead_s1;
	logic       nz_s1;
	logic       neg_s1;
	logic [53:0] rnd;
	logic        sticky;
	logic [10:0] ex;
	logic [51:0] frac;

	// leading one search
	always_comb begin
		lead = '0;
		nz   = 1'b0;
		for (int i = 0; i < WordBits; i++) begin
			if (mag[i]) begin
				lead = 6'(i);
				nz   = 1'b1;
			end
		end
	end

	// normalise so the leading one sits at bit 63
	always_ff @(posedge clk) begin
		if (en) begin
			norm_s1 <= mag << (6'd63 - lead);
			lead_s1 <= lead;
			nz_s1   <= nz;
			neg_s1  <= neg;
		end
	end

	// round and pack
	always_comb begin
		sticky = norm_s1[9:0] != '0;
		rnd = {1'b0, norm_s1[63:11]};
		if (norm_s1[10] && (sticky || norm_s1[11])) rnd = rnd + 54'd1;
		ex = 11'd1023 + 11'(lead_s1) + 11'(rnd[53]);
		frac = rnd[53] ? rnd[52:1] : rnd[51:0];
		result = nz_s1 ? {neg_s1, ex, frac} : '0;
	end
endmodule
`default_nettype wire

// File: hw/rtl/fp64_operand_bitwise_shift_unit.sv
// top level of the binary64 operand bitwise and shift unit
`default_nettype none
// Bitwise and shift unit for binary64 registers: truncates both operands to 64-bit
// integers, applies rol/ror/and/nor/or/sla/sll/sra/srl/xor and converts back with
// round to nearest even. Four register stages (truncate, operate, normalise, round);
// one word per cycle unless a valid output word is stalled, which freezes the whole
// pipeline; the output stage holds its word while stall is high.
module fp64_operand_bitwise_shift_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [3:0]  kind,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire logic [4:0]  dest_register,
	input  wire logic        operands_ok,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        write_enable,
	output      logic [4:0]  dest_register_out,
	output      logic [63:0] result_bits
);
	import fpbs_pkg::*;

	logic       adv;
	logic       v_s1, v_s2, v_s3, v_s4;
	word_t      ua_s1, ub_s1, sa_s1, sb_s1;
	logic [3:0] kind_s1;
	logic [4:0] dst_s1, dst_s2, dst_s3;
	logic       ok_s1, we_s2, we_s3;
	word_t      mag, mag_s2;
	logic       neg, neg_s2;
	logic       we;
	logic [5:0] n;
	word_t      conv;

	// whole pipeline moves unless the output word is held
	assign adv      = !(v_s4 && out_stall);
	assign in_stall = !adv;

	// stage 1: operand truncation
	always_ff @(posedge clk) begin
		if (adv) begin
			ua_s1   <= to_unsigned(operand_a);
			ub_s1   <= to_unsigned(operand_b);
			sa_s1   <= to_signed(operand_a);
			sb_s1   <= to_signed(operand_b);
			kind_s1 <= kind;
			dst_s1  <= dest_register;
			ok_s1   <= operands_ok;
		end
	end

	// stage 2: the operation
	always_comb begin
		n   = sb_s1[5:0];
		mag = '0;
		neg = 1'b0;
		we  = ok_s1;
		unique case (kind_s1)
			OP_ROL: mag = (ua_s1 << n) | (ua_s1 >> (7'd64 - {1'b0, n}));
			OP_ROR: mag = (ua_s1 >> n) | (ua_s1 << (7'd64 - {1'b0, n}));
			OP_AND: mag = ua_s1 & ub_s1;
			OP_NOR: mag = ~(sa_s1 | sb_s1);
			OP_OR:  mag = ua_s1 | ub_s1;
			OP_SLA: mag = sa_s1 << n;
			OP_SLL: mag = ua_s1 << n;
			OP_SRA: mag = word_t'($signed(sa_s1) >>> n);
			OP_SRL: mag = ua_s1 >> n;
			OP_XOR: mag = ua_s1 ^ ub_s1;
			default: we = 1'b0;
		endcase
		if (kind_s1 == OP_NOR || kind_s1 == OP_SLA || kind_s1 == OP_SRA) begin
			neg = mag[63];
			if (neg) mag = word_t'(0) - mag;
		end
		if (!we) mag = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag;
			neg_s2 <= neg;
			we_s2  <= we;
			dst_s2 <= dst_s1;
		end
	end

	// stages 3 and 4: conversion back to binary64
	fpbs_int_to_f64 u_conv (
		.clk    (clk),
		.en     (adv),
		.mag    (mag_s2),
		.neg    (neg_s2),
		.result (conv)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s3  <= we_s2;
			dst_s3 <= dst_s2;
			write_enable      <= we_s3;
			dest_register_out <= dst_s3;
			result_bits       <= conv;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
endmodule
`default_nettype wire

// File: hw/rtl/fpbs_checker.sv
// port level checker for the bitwise shift unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module fpbs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        write_enable,
	input wire logic [63:0] result_bits
);
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_bits), "word moved")
	`ASSERT_IMPL(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall, "stray input stall")
	`ASSERT_IMPL(a_zero, clk, arst_n, out_valid && !write_enable, result_bits == 64'd0, "stray data")
	`ASSERT_IMPL(a_negz, clk, arst_n, out_valid, result_bits != 64'h8000000000000000, "negative zero")
endmodule

bind fp64_operand_bitwise_shift_unit fpbs_checker u_fpbs_checker (
	.clk (clk), .arst_n (arst_n), .in_stall (in_stall),
	.out_valid (out_valid), .out_stall (out_stall), .write_enable (write_enable),
	.result_bits (result_bits)
);
`default_nettype wire

// File: tb/sv/fpbs_result_checker.sv
// checker that predicts and compares the result words of the bitwise shift unit
`timescale 1ns / 100ps
`default_nettype none
module fpbs_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [3:0]  kind,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire logic [4:0]  dest_register,
	input  wire logic        operands_ok,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        write_enable,
	input  wire logic [4:0]  dest_register_out,
	input  wire logic [63:0] result_bits,
	output int               fail_count,
	output int               pending_count
);
	import fpbs_pkg::*;

	typedef struct packed {
		logic        we;
		logic [4:0]  dest;
		logic [63:0] bits;
	} result_word_t;

	result_word_t expected_words[$];

	// truncate toward zero: magnitude, sign and overflow past 2^64
	function automatic logic [63:0] trunc_magnitude(input logic [63:0] x, output logic neg,
			output logic ovf);
		logic [10:0] e;
		logic [63:0] sig;
		e = x[62:52];
		sig = {11'd0, 1'b1, x[51:0]};
		neg = x[63];
		ovf = 1'b0;
		if (e == 11'h7ff) begin
			if (x[51:0] != 0) neg = 1'b0;
			else ovf = 1'b1;
			return 64'd0;
		end
		if (e < 11'd1023) return 64'd0;
		if (e >= 11'd1075) begin
			if (e - 11'd1075 > 11) begin
				ovf = 1'b1;
				return 64'd0;
			end
			return sig << (e - 11'd1075);
		end
		return sig >> (11'd1075 - e);
	endfunction

	function automatic logic [63:0] signed_int(input logic [63:0] x);
		logic neg, ovf;
		logic [63:0] mag;
		mag = trunc_magnitude(x, neg, ovf);
		if (!neg) return (ovf || mag[63]) ? 64'h7fff_ffff_ffff_ffff : mag;
		if (ovf || mag > 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
		return 64'd0 - mag;
	endfunction

	function automatic logic [63:0] unsigned_int(input logic [63:0] x);
		logic neg, ovf;
		logic [63:0] mag;
		mag = trunc_magnitude(x, neg, ovf);
		if (neg) return signed_int(x);
		if (ovf) return '1;
		return mag;
	endfunction

	// magnitude to binary64, round to nearest even
	function automatic logic [63:0] magnitude_to_double(input logic [63:0] mag,
			input logic neg);
		int p, rs;
		logic [63:0] keep, rem, half;
		if (mag == 0) return 64'd0;
		p = 63;
		while (!mag[p]) p--;
		if (p <= 52) keep = mag << (52 - p);
		else begin
			rs = p - 52;
			rem = mag & ((64'd1 << rs) - 1);
			half = 64'd1 << (rs - 1);
			keep = mag >> rs;
			if (rem > half || (rem == half && keep[0])) begin
				keep++;
				if (keep == (64'd1 << 53)) begin
					keep >>= 1;
					p++;
				end
			end
		end
		return {neg, 11'(p + 1023), keep[51:0]};
	endfunction

	function automatic logic [63:0] signed_to_double(input logic [63:0] v);
		if (v[63]) return magnitude_to_double(64'd0 - v, 1'b1);
		return magnitude_to_double(v, 1'b0);
	endfunction

	function automatic result_word_t predict_result(input logic [3:0] k, input logic [63:0] a,
			input logic [63:0] b, input logic [4:0] dest, input logic ok);
		result_word_t r;
		int n;
		logic [63:0] ua, ub, sa, sb;
		ua = unsigned_int(a);
		ub = unsigned_int(b);
		sa = signed_int(a);
		sb = signed_int(b);
		n = int'(sb[5:0]);
		r.we = ok;
		r.dest = dest;
		r.bits = 64'd0;
		case (k)
			OP_ROL: r.bits = magnitude_to_double(n == 0 ? ua : (ua << n) | (ua >> (64 - n)),
				1'b0);
			OP_ROR: r.bits = magnitude_to_double(n == 0 ? ua : (ua >> n) | (ua << (64 - n)),
				1'b0);
			OP_AND: r.bits = magnitude_to_double(ua & ub, 1'b0);
			OP_NOR: r.bits = signed_to_double(~(sa | sb));
			OP_OR:  r.bits = magnitude_to_double(ua | ub, 1'b0);
			OP_SLA: r.bits = signed_to_double(sa << n);
			OP_SLL: r.bits = magnitude_to_double(ua << n, 1'b0);
			OP_SRA: r.bits = signed_to_double($signed(sa) >>> n);
			OP_SRL: r.bits = magnitude_to_double(ua >> n, 1'b0);
			OP_XOR: r.bits = magnitude_to_double(ua ^ ub, 1'b0);
			default: r.we = 1'b0;
		endcase
		if (!r.we) r.bits = 64'd0;
		return r;
	endfunction

	assign pending_count = expected_words.size();

	// predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		result_word_t exp_word;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			expected_words.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_words.push_back(predict_result(kind, operand_a, operand_b,
					dest_register, operands_ok));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word");
					errs++;
				end else begin
					exp_word = expected_words.pop_front();
					if (write_enable !== exp_word.we) begin
						$error("write_enable expected %0b got %0b", exp_word.we, write_enable);
						errs++;
					end
					if (dest_register_out !== exp_word.dest) begin
						$error("dest_register_out expected %0d got %0d", exp_word.dest,
							dest_register_out);
						errs++;
					end
					if (result_bits !== exp_word.bits) begin
						$error("result_bits expected %h got %h", exp_word.bits, result_bits);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_fp64_operand_bitwise_shift_unit.sv
// testbench top: stimulus, stalls and verdict for the bitwise shift unit
`timescale 1ns / 100ps
`default_nettype none
module tb_fp64_operand_bitwise_shift_unit;
	import fpbs_pkg::*;

	localparam int RandomWords = 1650;
	localparam int IdleLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  kind = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic [4:0]  dest_register = '0;
	logic        operands_ok = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_enable;
	logic [4:0]  dest_register_out;
	logic [63:0] result_bits;
	int          fail_count;
	int          pending_count;
	int          idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fp64_operand_bitwise_shift_unit uut (.*);

	fpbs_result_checker checker_inst (.*);

	// gap length: mostly short, now and then long
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// operand patterns biased toward integer-valued doubles
	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		int r;
		v = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r < 5) v[62:52] = 11'(1023 + $urandom_range(0, 65));
		else if (r == 5) v[62:52] = 11'(1023 + $urandom_range(0, 6));
		else if (r == 6) v[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'd0;
		else if (r == 7) v[62:52] = 11'(1080 + $urandom_range(0, 10));
		return v;
	endfunction

	// present one word and hold it until accepted
	task automatic send_word(input logic [3:0] k, input logic [63:0] a, input logic [63:0] b,
			input logic [4:0] d, input logic ok);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand_a <= a;
		operand_b <= b;
		dest_register <= d;
		operands_ok <= ok;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// receiver stalls: stretches with none, others random
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				out_stall <= (mode != 0) && (gap_length() > 0);
			end
		end
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] edge_vals[12];
		edge_vals = '{64'h0, 64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,
			64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
			64'h43e0_0000_0000_0000, 64'hc3e0_0000_0000_0000, 64'h43f0_0000_0000_0000,
			64'h43ef_ffff_ffff_ffff, 64'h000f_ffff_ffff_ffff, 64'h404f_8000_0000_0000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every operation over edge operands, unused kinds, unresolved operands
		for (int k = 0; k < 10; k++)
			send_word(4'(k), edge_vals[k + 2], edge_vals[(k * 5) % 12], 5'(k), 1'b1);
		send_word(4'd10, edge_vals[1], edge_vals[1], 5'd17, 1'b1);
		send_word(4'd15, edge_vals[1], edge_vals[1], 5'd31, 1'b1);
		send_word(OP_OR, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd0, 1'b0);
		send_word(OP_ROL, 64'h43ef_ffff_ffff_ffff, 64'h404f_8000_0000_0000, 5'd3, 1'b1);
		send_word(OP_SLA, 64'hc000_0000_0000_0000, 64'h404f_8000_0000_0000, 5'd4, 1'b1);
		send_word(OP_SRA, 64'hc3e0_0000_0000_0000, 64'h4050_0000_0000_0000, 5'd5, 1'b1);
		send_word(OP_SRL, 64'hbff0_0000_0000_0000, 64'h3ff0_0000_0000_0000, 5'd6, 1'b1);
		send_word(OP_XOR, 64'h43f0_0000_0000_0000, 64'h3fe0_0000_0000_0000, 5'd7, 1'b1);
		// random words
		for (int i = 0; i < RandomWords; i++)
			send_word($urandom_range(0, 99) < 95 ? 4'($urandom_range(0, 9)) : 4'($urandom),
				random_operand(), random_operand(), 5'($urandom),
				$urandom_range(0, 9) != 0);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/fpbs_pkg.sv
hw/rtl/fpbs_int_to_f64.sv
hw/rtl/fp64_operand_bitwise_shift_unit.sv
hw/rtl/fpbs_checker.sv
tb/sv/fpbs_result_checker.sv
tb/sv/tb_fp64_operand_bitwise_shift_unit.sv
